// ===== sv/skvt_pkg.sv =====
// Shared types and codes for the sorted key/value table.
package skvt_pkg;

   // Operation carried by a request transaction
   typedef enum logic [1:0] {
      KIND_GET    = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_SET    = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // Request payload
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  key;
      logic [31:0] item_value;
   } req_type;

   // Response payload
   typedef struct packed {
      status_type  status;
      logic [4:0]  slot;
      logic [31:0] read_value;
      logic [5:0]  fill_count;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;        // capture request, restart scan
      logic       scan_rd;     // read entry at scan pointer
      logic       scan_cmp;    // compare read entry with key
      logic       sh_load_ins; // shift pointer to count (insert)
      logic       sh_load_rem; // shift pointer to match index (remove)
      logic       sh_rd;       // read shift source entry
      logic       sh_wr;       // write shift destination entry
      logic       wr_new;      // write key/value at scan pointer
      logic       cnt_inc;
      logic       cnt_dec;
      logic       res_load;    // load response register
      status_type res_code;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      kind_type kind;
      logic     at_end;   // scan pointer reached count
      logic     cmp_eq;   // read key equals request key
      logic     cmp_gt;   // read key above request key
      logic     found;
      logic     full;
      logic     sh_done;
      logic     out_free; // response register can take a result
   } stat_type;

endpackage

// ===== sv/skvt_ram.sv =====
// Generic single write, single read RAM with registered read data.
module skvt_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/skvt_ctrl.sv =====
// Controller state machine for the sorted key/value table.
module skvt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  skvt_pkg::stat_type stat,
   output skvt_pkg::cmd_type  cmd
);

   import skvt_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_SCAN_RD   = 8'b0000_0010,
      S_SCAN_CMP  = 8'b0000_0100,
      S_DECIDE    = 8'b0000_1000,
      S_SHIFT_RD  = 8'b0001_0000,
      S_SHIFT_WR  = 8'b0010_0000,
      S_WRITE_NEW = 8'b0100_0000,
      S_FINISH    = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      cmd          = '0;
      cmd.res_code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.at_end) begin
               state_in = S_DECIDE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            if (stat.cmp_eq || stat.cmp_gt) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            unique case (stat.kind)
               KIND_GET: begin
                  code_in = stat.found ? ST_OK : ST_NOT_FOUND;
               end
               KIND_ADD: begin
                  priority if (stat.full) begin
                     code_in = ST_FULL;
                  end else if (stat.found) begin
                     code_in    = ST_OK;
                     cmd.wr_new = 1'b1;
                  end else begin
                     code_in         = ST_OK;
                     cmd.sh_load_ins = 1'b1;
                     state_in        = S_SHIFT_RD;
                  end
               end
               KIND_SET: begin
                  if (stat.found) begin
                     code_in    = ST_OK;
                     cmd.wr_new = 1'b1;
                  end else begin
                     code_in = ST_NOT_FOUND;
                  end
               end
               KIND_REMOVE: begin
                  if (stat.found) begin
                     code_in         = ST_OK;
                     cmd.sh_load_rem = 1'b1;
                     state_in        = S_SHIFT_RD;
                  end else begin
                     code_in = ST_NOT_FOUND;
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            priority if (!stat.sh_done) begin
               cmd.sh_rd = 1'b1;
               state_in  = S_SHIFT_WR;
            end else if (stat.kind == KIND_ADD) begin
               state_in = S_WRITE_NEW;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.sh_wr = 1'b1;
            state_in  = S_SHIFT_RD;
         end
         S_WRITE_NEW: begin
            cmd.wr_new  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result code, set when the operation is decided
   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_SCAN_RD)
      else $error("accepted transaction did not start a scan");

   a_result_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> stat.out_free)
      else $error("result loaded while response register busy");

endmodule

// ===== sv/skvt_dp.sv =====
// Datapath of the sorted key/value table: entry RAM, pointers, count, response.
module skvt_dp #(
   parameter int TABLE_DEPTH = 32,
   parameter int KEY_WIDTH   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  skvt_pkg::req_type  req_payload,
   input  skvt_pkg::cmd_type  cmd,
   output skvt_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output skvt_pkg::rsp_type  rsp_payload
);

   import skvt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int WW = KEY_WIDTH + 32;

   // Captured transaction
   kind_type             kind_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [31:0]          val_ff;

   // Pointers and count
   logic [CW-1:0] scan_ptr_ff, sh_ptr_ff, count_ff;
   logic          found_ff;
   logic [31:0]   found_val_ff;

   // Response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // RAM port signals
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [WW-1:0] ram_wr_data, ram_rd_data;

   logic [KEY_WIDTH-1:0] rd_key;
   logic [CW-1:0]        sh_src;
   logic                 is_ins;

   assign rd_key = ram_rd_data[WW-1:32];
   assign is_ins = (kind_ff == KIND_ADD);
   assign sh_src = is_ins ? (sh_ptr_ff - CW'(1)) : (sh_ptr_ff + CW'(1));

   // Status towards the controller
   always_comb begin
      stat.kind     = kind_ff;
      stat.at_end   = (scan_ptr_ff == count_ff);
      stat.cmp_eq   = (rd_key == key_ff);
      stat.cmp_gt   = (rd_key > key_ff);
      stat.found    = found_ff;
      stat.full     = (count_ff == CW'(TABLE_DEPTH));
      stat.sh_done  = is_ins ? (sh_ptr_ff == scan_ptr_ff)
                             : ((sh_ptr_ff + CW'(1)) == count_ff);
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   // RAM addressing: scan and shift reads, shift and new-entry writes
   always_comb begin
      ram_rd_en   = cmd.scan_rd || cmd.sh_rd;
      ram_rd_addr = cmd.scan_rd ? scan_ptr_ff[AW-1:0] : sh_src[AW-1:0];
      ram_wr_en   = cmd.sh_wr || cmd.wr_new;
      ram_wr_addr = cmd.sh_wr ? sh_ptr_ff[AW-1:0] : scan_ptr_ff[AW-1:0];
      ram_wr_data = cmd.sh_wr ? ram_rd_data : {key_ff, val_ff};
   end

   skvt_ram #(
      .WIDTH (WW),
      .DEPTH (TABLE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_payload.kind;
         key_ff  <= KEY_WIDTH'(req_payload.key);
         val_ff  <= req_payload.item_value;
      end
   end

   // Scan pointer and match capture
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff <= '0;
         found_ff    <= 1'b0;
      end else if (cmd.load) begin
         scan_ptr_ff <= '0;
         found_ff    <= 1'b0;
      end else if (cmd.scan_cmp) begin
         if (stat.cmp_eq) begin
            found_ff <= 1'b1;
         end else if (!stat.cmp_gt) begin
            scan_ptr_ff <= scan_ptr_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_cmp && stat.cmp_eq) begin
         found_val_ff <= ram_rd_data[31:0];
      end
   end

   // Shift pointer: walks down for insert, up for remove
   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ptr_ff <= '0;
      end else if (cmd.sh_load_ins) begin
         sh_ptr_ff <= count_ff;
      end else if (cmd.sh_load_rem) begin
         sh_ptr_ff <= scan_ptr_ff;
      end else if (cmd.sh_wr) begin
         sh_ptr_ff <= sh_src;
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.cnt_inc) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_ff.status     <= cmd.res_code;
         rsp_ff.slot       <= (cmd.res_code == ST_OK) ? 5'(scan_ptr_ff) : 5'd0;
         rsp_ff.read_value <= (cmd.res_code == ST_OK && kind_ff == KIND_GET)
                              ? found_val_ff : 32'd0;
         rsp_ff.fill_count <= 6'(count_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |=> count_ff == CW'($past(count_ff) + CW'(1)))
      else $error("insert did not raise the entry count by one");

endmodule

// ===== sv/sorted_key_value_table_unit.sv =====
// Top level of the sorted key/value table: controller plus datapath.
// Operation: a linear scan examines entries (stops at the first key not below
//   the request key); an insert or remove then moves entries one at a time;
//   the remaining steps are end-of-scan check, decision, end-of-shift check,
//   new-entry write and response loading.
// Flow: one transaction in flight; the next is taken in the cycle after the
//   result is loaded. Loading waits while the response register is still held.
// Reset clears the entry count and response valid; table RAM is not cleared.
module sorted_key_value_table_unit #(
   parameter int TABLE_DEPTH = 32,
   parameter int KEY_WIDTH   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skvt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output skvt_pkg::rsp_type rsp_payload
);

   import skvt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   skvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   skvt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== dv/tb_sorted_key_value_table_unit.sv =====
// Self-checking testbench for the sorted key/value table unit.
`timescale 1ns / 1ps

module tb_sorted_key_value_table_unit;
   import skvt_pkg::*;

   localparam int DEPTH       = 32;
   localparam int TAIL_CYCLES = 200;     // beyond the longest scan plus shift
   localparam int HOLD_CYCLES = 400;     // long receiver hold-off
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 300;

   // Directed stimulus row; want is used only where fixed is set
   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type want;
   } op_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   // Table contents as they should be after every accepted transaction
   logic [7:0]  tbl_keys [DEPTH];
   logic [31:0] tbl_vals [DEPTH];
   int          tbl_count = 0;

   rsp_type    pending_results[$];
   rsp_type    want;
   op_row_type directed_rows[$];

   int cycle_count   = 0;
   int mismatches    = 0;
   int sent_count    = 0;
   int n_ok          = 0;
   int n_not_found   = 0;
   int n_full        = 0;
   int times_full    = 0;
   int times_empty   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked    = 0;
   int hold_taken    = 0;
   int hold_left     = 0;

   sorted_key_value_table_unit #(
      .TABLE_DEPTH(DEPTH),
      .KEY_WIDTH  (8)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Applies one operation to the table image and returns its result
   function automatic rsp_type table_apply(req_type r);
      rsp_type res;
      int      hit;
      int      pos;
      res = '{status: ST_OK, slot: 5'd0, read_value: 32'd0, fill_count: 6'd0};
      hit = -1;
      for (int i = 0; i < tbl_count; i++) begin
         if (hit < 0 && tbl_keys[i] == r.key) hit = i;
      end
      case (r.kind)
         KIND_GET: begin
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               res.slot       = 5'(hit);
               res.read_value = tbl_vals[hit];
            end
         end
         KIND_ADD: begin
            // full table refuses even an overwrite
            if (tbl_count >= DEPTH) begin
               res.status = ST_FULL;
            end else if (hit >= 0) begin
               res.slot      = 5'(hit);
               tbl_vals[hit] = r.item_value;
            end else begin
               pos = tbl_count;
               for (int i = tbl_count - 1; i >= 0; i--) begin
                  if (tbl_keys[i] > r.key) pos = i;
               end
               for (int i = tbl_count; i > pos; i--) begin
                  tbl_keys[i] = tbl_keys[i - 1];
                  tbl_vals[i] = tbl_vals[i - 1];
               end
               tbl_keys[pos] = r.key;
               tbl_vals[pos] = r.item_value;
               tbl_count++;
               res.slot = 5'(pos);
            end
         end
         KIND_SET: begin
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               res.slot      = 5'(hit);
               tbl_vals[hit] = r.item_value;
            end
         end
         default: begin
            // remove closes the gap
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               res.slot = 5'(hit);
               for (int i = hit + 1; i < tbl_count; i++) begin
                  tbl_keys[i - 1] = tbl_keys[i];
                  tbl_vals[i - 1] = tbl_vals[i];
               end
               tbl_count--;
            end
         end
      endcase
      res.fill_count = 6'(tbl_count);
      return res;
   endfunction

   function automatic op_row_type op_row(kind_type kind, logic [7:0] key, logic [31:0] val,
                                         bit fixed, status_type st, logic [4:0] slot,
                                         logic [31:0] rv, logic [5:0] cnt);
      op_row_type row;
      row.req   = '{kind: kind, key: key, item_value: val};
      row.fixed = fixed;
      row.want  = '{status: st, slot: slot, read_value: rv, fill_count: cnt};
      return row;
   endfunction

   // Offers one transaction, waits for acceptance, then records its expected result
   task automatic offer(req_type r, bit fixed, rsp_type fixed_want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = table_apply(r);
      pending_results.push_back(fixed ? fixed_want : predicted);
      sent_count++;
      case (predicted.status)
         ST_OK:        n_ok++;
         ST_NOT_FOUND: n_not_found++;
         default:      n_full++;
      endcase
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with nothing outstanding: %p", rsp_payload);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
               mismatches++;
            end
            if (rsp_payload.slot !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_payload.slot);
               mismatches++;
            end
            if (rsp_payload.read_value !== want.read_value) begin
               $error("read_value: expected %h, actual %h", want.read_value,
                      rsp_payload.read_value);
               mismatches++;
            end
            if (rsp_payload.fill_count !== want.fill_count) begin
               $error("fill_count: expected %0d, actual %0d", want.fill_count,
                      rsp_payload.fill_count);
               mismatches++;
            end
         end
      end
   end

   // Timeout
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
   end

   // Stimulus
   initial begin
      req_type    r;
      rsp_type    none;
      kind_type   kind;
      int         roll;
      int         reuse_pct;
      int         at_limit;
      bit         fill_mode;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      none        = '0;
      fill_mode   = 1'b1;
      at_limit    = 0;

      // Empty table, extremes of key and value, overwrite, misses, then drain
      directed_rows.push_back(op_row(KIND_GET,    8'h00, 32'h0, 1, ST_NOT_FOUND, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_SET,    8'h7F, 32'h1, 1, ST_NOT_FOUND, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_REMOVE, 8'hFF, 32'h0, 1, ST_NOT_FOUND, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_GET,    8'h7F, 32'h0, 1, ST_NOT_FOUND, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_ADD,    8'h80, 32'hFFFF_FFFF, 1, ST_OK, 0, 0, 1));
      directed_rows.push_back(op_row(KIND_ADD,    8'h00, 32'h0, 1, ST_OK, 0, 0, 2));
      directed_rows.push_back(op_row(KIND_ADD,    8'hFF, 32'hA5A5_A5A5, 1, ST_OK, 2, 0, 3));
      directed_rows.push_back(op_row(KIND_GET,    8'hFF, 32'h0, 1, ST_OK, 2, 32'hA5A5_A5A5, 3));
      directed_rows.push_back(op_row(KIND_GET,    8'h80, 32'h0, 1, ST_OK, 1, 32'hFFFF_FFFF, 3));
      directed_rows.push_back(op_row(KIND_ADD,    8'h80, 32'h5A5A_5A5A, 1, ST_OK, 1, 0, 3));
      directed_rows.push_back(op_row(KIND_SET,    8'h00, 32'h1234_5678, 1, ST_OK, 0, 0, 3));
      directed_rows.push_back(op_row(KIND_GET,    8'h00, 32'h0, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_GET,    8'h80, 32'h0, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_SET,    8'h40, 32'hFFFF_FFFF, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_GET,    8'h41, 32'h0, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_REMOVE, 8'h41, 32'h0, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_ADD,    8'h40, 32'h0000_FFFF, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_REMOVE, 8'h00, 32'hFFFF_FFFF, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_GET,    8'h40, 32'h0, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_REMOVE, 8'hFF, 32'h0, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_REMOVE, 8'h80, 32'h0, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_REMOVE, 8'h40, 32'h0, 0, ST_OK, 0, 0, 0));
      directed_rows.push_back(op_row(KIND_REMOVE, 8'h40, 32'h0, 1, ST_NOT_FOUND, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 24;
      recv_idle_pct = 88;
      foreach (directed_rows[i]) begin
         offer(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);
      end
      wait_all_results();

      // Random phases: slow receiver, slow sender, then no idling
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 88 : 0;
         recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 24 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender pauses until the block has returned everything
            if (phase == 0 && n == PHASE_ITEMS / 2) wait_all_results();
            // receiver holds off while the sender keeps offering
            if (phase == 2 && n == PHASE_ITEMS / 3) hold_asked <= hold_asked + 1;

            // mostly fill-then-drain sweeps, some pure noise
            roll = $urandom_range(99);
            if ($urandom_range(99) < 10) begin
               kind = kind_type'($urandom_range(3));
            end else if (fill_mode) begin
               kind = (roll < 60) ? KIND_ADD : (roll < 75) ? KIND_GET :
                      (roll < 88) ? KIND_SET : KIND_REMOVE;
            end else begin
               kind = (roll < 60) ? KIND_REMOVE : (roll < 72) ? KIND_ADD :
                      (roll < 87) ? KIND_GET : KIND_SET;
            end
            r.kind    = kind;
            reuse_pct = (kind == KIND_ADD && tbl_count < DEPTH) ? 25 : 70;
            roll      = $urandom_range(99);
            if (tbl_count > 0 && roll < reuse_pct) begin
               r.key = tbl_keys[$urandom_range(tbl_count - 1)];
            end else if (roll < reuse_pct + 10) begin
               r.key = $urandom_range(1) ? 8'hFF : 8'h00;
            end else begin
               r.key = 8'($urandom_range(255));
            end
            roll = $urandom_range(99);
            r.item_value = (roll < 5) ? 32'h0 : (roll < 10) ? 32'hFFFF_FFFF : $urandom;
            offer(r, 1'b0, none);

            // switch sweep direction once the table has sat at its limit a while
            if ((fill_mode && tbl_count == DEPTH) || (!fill_mode && tbl_count == 0)) begin
               if (at_limit == 0) begin
                  if (fill_mode) times_full++;
                  else times_empty++;
               end
               at_limit++;
               if (at_limit >= 6) begin
                  fill_mode = !fill_mode;
                  at_limit  = 0;
               end
            end else begin
               at_limit = 0;
            end
         end
         wait_all_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d transactions: %0d ok, %0d key not found, %0d table full",
               sent_count, n_ok, n_not_found, n_full);
      $display("Table swept to full %0d times and back to empty %0d times",
               times_full, times_empty);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/skvt_pkg.sv
sv/skvt_ram.sv
sv/skvt_ctrl.sv
sv/skvt_dp.sv
sv/sorted_key_value_table_unit.sv
dv/tb_sorted_key_value_table_unit.sv
